// ----- hw/rtl/crv_pkg.sv -----
// Shared constants, types and arithmetic helpers for the comb/allpass reverb core.
`timescale 1ns / 1ps

package crv_pkg;

   localparam int MAX_COMB_LEN    = 2048;
   localparam int MAX_ALLPASS_LEN = 256;
   localparam int NUM_COMBS       = 4;

   localparam int COMB_AW   = $clog2(MAX_COMB_LEN);
   localparam int AP_AW     = $clog2(MAX_ALLPASS_LEN);
   localparam int CLR_DEPTH = (MAX_COMB_LEN > MAX_ALLPASS_LEN) ? MAX_COMB_LEN : MAX_ALLPASS_LEN;
   localparam int CLR_AW    = $clog2(CLR_DEPTH);

   localparam int SAMPLE_W   = 24;
   localparam int VAL_W      = 28;
   localparam int GAIN_W     = 16;
   localparam int LEN_W      = 12;
   localparam int AP_LEN_W   = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int PROD_W     = VAL_W + GAIN_W + 1;
   localparam int RND_W      = PROD_W - GAIN_W;
   localparam int SUM_W      = VAL_W + 2;

   localparam logic signed [PROD_W-1:0]   ROUND_HALF = PROD_W'(2 ** (GAIN_W - 1));
   localparam logic signed [SUM_W-1:0]    VAL_HI     = SUM_W'(2 ** (VAL_W - 1) - 1);
   localparam logic signed [SUM_W-1:0]    VAL_LO     = -VAL_HI - SUM_W'(1);
   localparam logic signed [VAL_W-1:0]    SMP_HI     = VAL_W'(2 ** (SAMPLE_W - 1) - 1);
   localparam logic signed [VAL_W-1:0]    SMP_LO     = -SMP_HI - VAL_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COMB_LEN_A,
      REG_COMB_LEN_B,
      REG_COMB_LEN_C,
      REG_COMB_LEN_D,
      REG_AP_LEN,
      REG_COMB_FB,
      REG_AP_GAIN
   } crv_reg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SUM,
      ST_COMB_WR,
      ST_AP_Y,
      ST_AP_MUL,
      ST_AP_WR
   } crv_state_type;

   typedef struct packed {
      logic [NUM_COMBS-1:0][LEN_W-1:0] comb_len;
      logic [AP_LEN_W-1:0]             ap_len;
      logic [GAIN_W-1:0]               comb_fb;
      logic [GAIN_W-1:0]               ap_gain;
   } crv_cfg_type;

   typedef struct packed {
      logic req_ready;
      logic rd_en;
      logic sum_en;
      logic comb_we;
      logic ap_mul1_en;
      logic y_en;
      logic ap_mul2_en;
      logic ap_we;
      logic rsp_load;
      logic zero_fill;
   } crv_ctrl_type;

   function automatic logic signed [PROD_W-1:0] gain_mul(input logic signed [VAL_W-1:0] v,
                                                          input logic [GAIN_W-1:0] g);
      logic signed [GAIN_W:0] gs;
      gs = {1'b0, g};
      gain_mul = v * gs;
   endfunction

   // Q0.16 product back to value scale, round half up.
   function automatic logic signed [RND_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = p + ROUND_HALF;
      round_q16 = t[PROD_W-1:GAIN_W];
   endfunction

   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      if (v > VAL_HI) begin
         r = VAL_HI;
      end else if (v < VAL_LO) begin
         r = VAL_LO;
      end else begin
         r = v;
      end
      sat_val = r[VAL_W-1:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [VAL_W-1:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > SMP_HI) begin
         r = SMP_HI;
      end else if (v < SMP_LO) begin
         r = SMP_LO;
      end else begin
         r = v;
      end
      sat_sample = r[SAMPLE_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/crv_ram.sv -----
// Single-port synchronous delay-line RAM with registered read data.
`timescale 1ns / 1ps

module crv_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 28
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/crv_csr.sv -----
// Configuration register file: delay lengths and gains.
`timescale 1ns / 1ps

module crv_csr import crv_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output crv_cfg_type           cfg
);

   crv_cfg_type cfg_ff;
   crv_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_COMB_LEN_A: cfg_in.comb_len[0] = csr_data[LEN_W-1:0];
            REG_COMB_LEN_B: cfg_in.comb_len[1] = csr_data[LEN_W-1:0];
            REG_COMB_LEN_C: cfg_in.comb_len[2] = csr_data[LEN_W-1:0];
            REG_COMB_LEN_D: cfg_in.comb_len[3] = csr_data[LEN_W-1:0];
            REG_AP_LEN:     cfg_in.ap_len      = csr_data[AP_LEN_W-1:0];
            REG_COMB_FB:    cfg_in.comb_fb     = csr_data[GAIN_W-1:0];
            REG_AP_GAIN:    cfg_in.ap_gain     = csr_data[GAIN_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.comb_len[0] <= LEN_W'(1309);
         cfg_ff.comb_len[1] <= LEN_W'(1636);
         cfg_ff.comb_len[2] <= LEN_W'(1812);
         cfg_ff.comb_len[3] <= LEN_W'(1927);
         cfg_ff.ap_len      <= AP_LEN_W'(220);
         cfg_ff.comb_fb     <= GAIN_W'(55050);
         cfg_ff.ap_gain     <= GAIN_W'(45875);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

// ----- hw/rtl/crv_ctrl.sv -----
// Sequencer: clearing sweep, per-sample step control and delay-line pointers.
`timescale 1ns / 1ps

module crv_ctrl import crv_pkg::*; (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                rsp_free,
   input  crv_cfg_type                         cfg,
   output crv_ctrl_type                        ctrl,
   output logic [NUM_COMBS-1:0][COMB_AW-1:0]   comb_addr,
   output logic [AP_AW-1:0]                    ap_addr
);

   crv_state_type                       state_ff, state_in;
   logic [CLR_AW-1:0]                   clr_cnt_ff, clr_cnt_in;
   logic [NUM_COMBS-1:0][COMB_AW-1:0]   comb_ptr_ff, comb_ptr_in;
   logic [AP_AW-1:0]                    ap_ptr_ff, ap_ptr_in;
   logic                                clearing;

   function automatic logic [COMB_AW-1:0] comb_next(input logic [COMB_AW-1:0] p,
                                                   input logic [LEN_W-1:0] len);
      logic [COMB_AW:0] p1;
      logic             wrap;
      p1   = {1'b0, p} + (COMB_AW+1)'(1);
      wrap = (len == '0) || (int'(p1) >= int'(len)) || (int'(p1) >= MAX_COMB_LEN);
      comb_next = wrap ? '0 : p1[COMB_AW-1:0];
   endfunction

   function automatic logic [AP_AW-1:0] ap_next(input logic [AP_AW-1:0] p,
                                               input logic [AP_LEN_W-1:0] len);
      logic [AP_AW:0] p1;
      logic           wrap;
      p1   = {1'b0, p} + (AP_AW+1)'(1);
      wrap = (len == '0) || (int'(p1) >= int'(len)) || (int'(p1) >= MAX_ALLPASS_LEN);
      ap_next = wrap ? '0 : p1[AP_AW-1:0];
   endfunction

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == CLR_AW'(CLR_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM:     state_in = ST_COMB_WR;
         ST_COMB_WR: state_in = ST_AP_Y;
         ST_AP_Y:    state_in = ST_AP_MUL;
         ST_AP_MUL:  state_in = ST_AP_WR;
         ST_AP_WR: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      comb_ptr_in = comb_ptr_ff;
      ap_ptr_in   = ap_ptr_ff;
      if (state_ff == ST_CLEAR) begin
         clr_cnt_in = CLR_AW'(clr_cnt_ff + 1'b1);
      end
      if (state_ff == ST_COMB_WR) begin
         for (int i = 0; i < NUM_COMBS; i++) begin
            comb_ptr_in[i] = comb_next(comb_ptr_ff[i], cfg.comb_len[i]);
         end
      end
      if ((state_ff == ST_AP_WR) && rsp_free) begin
         ap_ptr_in = ap_next(ap_ptr_ff, cfg.ap_len);
      end
   end

   always_comb begin
      clearing        = (state_ff == ST_CLEAR);
      ctrl            = '0;
      ctrl.req_ready  = (state_ff == ST_IDLE);
      ctrl.rd_en      = (state_ff == ST_IDLE) && req_valid;
      ctrl.sum_en     = (state_ff == ST_SUM);
      ctrl.comb_we    = (state_ff == ST_COMB_WR) ||
                        (clearing && (int'(clr_cnt_ff) < MAX_COMB_LEN));
      ctrl.ap_mul1_en = (state_ff == ST_COMB_WR);
      ctrl.y_en       = (state_ff == ST_AP_Y);
      ctrl.ap_mul2_en = (state_ff == ST_AP_MUL);
      ctrl.ap_we      = ((state_ff == ST_AP_WR) && rsp_free) ||
                        (clearing && (int'(clr_cnt_ff) < MAX_ALLPASS_LEN));
      ctrl.rsp_load   = (state_ff == ST_AP_WR) && rsp_free;
      ctrl.zero_fill  = clearing;
      for (int i = 0; i < NUM_COMBS; i++) begin
         comb_addr[i] = clearing ? clr_cnt_ff[COMB_AW-1:0] : comb_ptr_ff[i];
      end
      ap_addr = clearing ? clr_cnt_ff[AP_AW-1:0] : ap_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_cnt_ff  <= '0;
         comb_ptr_ff <= '0;
         ap_ptr_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         clr_cnt_ff  <= clr_cnt_in;
         comb_ptr_ff <= comb_ptr_in;
         ap_ptr_ff   <= ap_ptr_in;
      end
   end

endmodule

// ----- hw/rtl/comb_allpass_reverb_core.sv -----
// Top level: four feedback comb lines into one allpass line, Q1.23 samples.
`timescale 1ns / 1ps
//
// One dry sample in per req_ beat, one wet sample out per rsp_ beat, in order.
// The comb and allpass delay lines live in single-port RAMs; each sample is a
// read of all five lines, a sum and feedback multiply, a comb write-back, then
// two dependent allpass multiplies and the allpass write-back.
// Samples are handled one at a time: a new req_ beat is taken only in idle,
// after the previous sample's allpass write-back, along the chain read ->
// comb multiply -> allpass multiply -> allpass multiply -> write through the
// RAM ports. A finished sample sits in the output register; the core takes
// the next sample meanwhile and holds in its last step only if that register
// is still occupied when the next result is ready. Reset clears the state,
// pointers and rsp_valid, then sweeps the delay lines to zero with req_ready
// low. csr_ writes are taken at any time but are meant for idle periods;
// csr_index 0..6 selects comb lengths a..d, allpass length, comb feedback
// and allpass gain.
//

module comb_allpass_reverb_core import crv_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_dry_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_wet_sample,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   crv_cfg_type                       cfg;
   crv_ctrl_type                      ctrl;
   logic [NUM_COMBS-1:0][COMB_AW-1:0] comb_addr;
   logic [AP_AW-1:0]                  ap_addr;
   logic [NUM_COMBS-1:0][VAL_W-1:0]   comb_rd;
   logic [NUM_COMBS-1:0][VAL_W-1:0]   comb_wd;
   logic [VAL_W-1:0]                  ap_rd;
   logic [VAL_W-1:0]                  ap_wd;
   logic                              rsp_free;

   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [PROD_W-1:0]   comb_prod_ff [NUM_COMBS];
   logic signed [VAL_W-1:0]    a_ff, a_in;
   logic signed [PROD_W-1:0]   ap_prod1_ff;
   logic signed [VAL_W-1:0]    y_ff, y_in;
   logic signed [PROD_W-1:0]   ap_prod2_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff;
   logic signed [SUM_W-1:0]    comb_sum;

   crv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   crv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_free  (rsp_free),
      .cfg       (cfg),
      .ctrl      (ctrl),
      .comb_addr (comb_addr),
      .ap_addr   (ap_addr)
   );

   for (genvar i = 0; i < NUM_COMBS; i++) begin : g_comb
      crv_ram #(
         .DEPTH (MAX_COMB_LEN),
         .WIDTH (VAL_W)
      ) u_line (
         .clock   (clock),
         .wr_en   (ctrl.comb_we),
         .rd_en   (ctrl.rd_en),
         .addr    (comb_addr[i]),
         .wr_data (comb_wd[i]),
         .rd_data (comb_rd[i])
      );
   end

   crv_ram #(
      .DEPTH (MAX_ALLPASS_LEN),
      .WIDTH (VAL_W)
   ) u_ap_line (
      .clock   (clock),
      .wr_en   (ctrl.ap_we),
      .rd_en   (ctrl.rd_en),
      .addr    (ap_addr),
      .wr_data (ap_wd),
      .rd_data (ap_rd)
   );

   // comb outputs summed, quarter scaling with round half up
   always_comb begin
      logic signed [SUM_W-1:0] t;
      comb_sum = '0;
      for (int i = 0; i < NUM_COMBS; i++) begin
         comb_sum = comb_sum + SUM_W'($signed(comb_rd[i]));
      end
      t    = comb_sum + SUM_W'(2);
      a_in = t[SUM_W-1:2];
   end

   always_comb begin
      for (int i = 0; i < NUM_COMBS; i++) begin
         comb_wd[i] = ctrl.zero_fill ? '0 :
                      sat_val(SUM_W'(x_ff) + SUM_W'(round_q16(comb_prod_ff[i])));
      end
      y_in  = sat_val(SUM_W'($signed(ap_rd)) - SUM_W'(round_q16(ap_prod1_ff)));
      ap_wd = ctrl.zero_fill ? '0 :
              sat_val(SUM_W'(a_ff) + SUM_W'(round_q16(ap_prod2_ff)));
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         x_ff <= req_dry_sample;
      end
      if (ctrl.sum_en) begin
         for (int i = 0; i < NUM_COMBS; i++) begin
            comb_prod_ff[i] <= gain_mul($signed(comb_rd[i]), cfg.comb_fb);
         end
         a_ff <= a_in;
      end
      if (ctrl.ap_mul1_en) begin
         ap_prod1_ff <= gain_mul(a_ff, cfg.ap_gain);
      end
      if (ctrl.y_en) begin
         y_ff <= y_in;
      end
      if (ctrl.ap_mul2_en) begin
         ap_prod2_ff <= gain_mul(y_ff, cfg.ap_gain);
      end
      if (ctrl.rsp_load) begin
         rsp_data_ff <= sat_sample(y_ff);
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready      = ctrl.req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_wet_sample = rsp_data_ff;

endmodule
